// File: hw/rtl/wfrm_pkg.sv
// ----------------------------------------------------------------------------
// wfrm_pkg
// Shared types and constants for the wildcard flow rule matcher: the packed
// rule layout, stream widths and the controller to datapath command set.
// ----------------------------------------------------------------------------
package wfrm_pkg;

	localparam int RULES_DEF  = 64;
	localparam int IN_DATA_W  = 328;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;
	localparam int INDEX_W    = 6;

	localparam logic OP_MATCH  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Declared high field first so that src_mac lands in the lowest bits,
	// matching the input tdata layout one for one.
	typedef struct packed {
		logic [31:0] action_low;
		logic [31:0] action_high;
		logic [31:0] ss_value;
		logic [31:0] hh_value;
		logic [15:0] l4_dport;
		logic [15:0] l4_sport;
		logic [7:0]  protocol;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
	} rule_t;

	typedef struct packed {
		logic load;      // capture an accepted input beat
		logic insert;    // append the held item as a rule
		logic scan_step; // read the next rule of the table
		logic capture;   // latch the deciding rule as the result
		logic emit;      // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic op;        // operation of the held item
		logic more;      // rules left to read
		logic pend;      // a rule read is in the compare stage
		logic decide;    // the compared rule decides the match
		logic out_free;  // the output register can take a result
	} stat_t;

endpackage

// File: hw/rtl/wfrm_ctrl.sv
// ----------------------------------------------------------------------------
// wfrm_ctrl
// Controller for the flow rule matcher: accepts a beat, dispatches an insert
// or a table scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module wfrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  wfrm_pkg::stat_t stat,
	output wfrm_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.op == wfrm_pkg::OP_INSERT) begin
					cmd.insert = 1'b1;
					state_d    = ST_FINISH;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// A decision in the compare stage wins over further reads.
				if (stat.decide) begin
					cmd.capture = 1'b1;
					state_d     = ST_FINISH;
				end else if (stat.more) begin
					cmd.scan_step = 1'b1;
				end else if (!stat.pend) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/wfrm_datapath.sv
// ----------------------------------------------------------------------------
// wfrm_datapath
// Rule memory, item register, scan pointer, one-rule compare stage, result
// register and output register of the flow rule matcher.
// ----------------------------------------------------------------------------
module wfrm_datapath #(
	parameter int RULES = wfrm_pkg::RULES_DEF,
	parameter int IDXW  = (RULES > 1) ? $clog2(RULES) : 1,
	parameter int CNTW  = $clog2(RULES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [wfrm_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tuser,
	input  wfrm_pkg::cmd_t                      cmd,
	output wfrm_pkg::stat_t                     stat,
	output logic [wfrm_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [wfrm_pkg::OUT_USER_W-1:0]     m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready
);

	wfrm_pkg::rule_t mem [RULES];

	wfrm_pkg::rule_t item_q;
	logic            op_q;
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] ptr_q;

	wfrm_pkg::rule_t rd_s1;
	logic [IDXW-1:0] idx_s1;
	logic            vld_s1;

	logic                          res_matched_q;
	logic [31:0]                   res_action_q;
	logic [wfrm_pkg::INDEX_W-1:0]  res_index_q;
	logic                          res_rejected_q;

	logic                          out_valid_q;
	logic                          out_matched_q;
	logic [31:0]                   out_action_q;
	logic [wfrm_pkg::INDEX_W-1:0]  out_index_q;
	logic                          out_rejected_q;

	logic                                full;
	logic                                hit;
	logic                                hh_over;
	logic                                ss_over;
	logic [IDXW+wfrm_pkg::INDEX_W-1:0]   count_ext;
	logic [IDXW+wfrm_pkg::INDEX_W-1:0]   idx_ext;

	assign full = (count_q == CNTW'(RULES));

	// Index outputs keep only their low bits when the table is deeper.
	assign count_ext = {{wfrm_pkg::INDEX_W{1'b0}}, count_q[IDXW-1:0]};
	assign idx_ext   = {{wfrm_pkg::INDEX_W{1'b0}}, idx_s1};

	// A zero rule field is a wildcard.
	assign hit = ((rd_s1.src_mac  == '0) || (rd_s1.src_mac  == item_q.src_mac))  &&
	             ((rd_s1.dst_mac  == '0) || (rd_s1.dst_mac  == item_q.dst_mac))  &&
	             ((rd_s1.src_ip   == '0) || (rd_s1.src_ip   == item_q.src_ip))   &&
	             ((rd_s1.dst_ip   == '0) || (rd_s1.dst_ip   == item_q.dst_ip))   &&
	             ((rd_s1.protocol == '0) || (rd_s1.protocol == item_q.protocol)) &&
	             ((rd_s1.l4_sport == '0) || (rd_s1.l4_sport == item_q.l4_sport)) &&
	             ((rd_s1.l4_dport == '0) || (rd_s1.l4_dport == item_q.l4_dport));

	assign hh_over = (item_q.hh_value > rd_s1.hh_value);
	assign ss_over = (item_q.ss_value > rd_s1.ss_value);

	assign stat.op       = op_q;
	assign stat.more     = (ptr_q < count_q);
	assign stat.pend     = vld_s1;
	assign stat.decide   = vld_s1 && hit && (hh_over || ss_over);
	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			mem[count_q[IDXW-1:0]] <= item_q;
		end
		if (cmd.scan_step) begin
			rd_s1  <= mem[ptr_q[IDXW-1:0]];
			idx_s1 <= ptr_q[IDXW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.insert && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
			vld_s1 <= cmd.scan_step;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q         <= wfrm_pkg::rule_t'(s_tdata);
			op_q           <= s_tuser;
			res_matched_q  <= 1'b0;
			res_action_q   <= '0;
			res_index_q    <= '0;
			res_rejected_q <= 1'b0;
		end
		if (cmd.insert) begin
			if (full) begin
				res_rejected_q <= 1'b1;
			end else begin
				res_index_q <= count_ext[wfrm_pkg::INDEX_W-1:0];
			end
		end
		if (cmd.capture) begin
			res_matched_q <= 1'b1;
			res_action_q  <= hh_over ? rd_s1.action_high : rd_s1.action_low;
			res_index_q   <= idx_ext[wfrm_pkg::INDEX_W-1:0];
		end
		if (cmd.emit) begin
			out_matched_q  <= res_matched_q;
			out_action_q   <= res_action_q;
			out_index_q    <= res_index_q;
			out_rejected_q <= res_rejected_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_index_q, out_action_q};
	assign m_tuser  = {out_rejected_q, out_matched_q};

endmodule

// File: hw/rtl/wildcard_flow_rule_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_flow_rule_matcher
// Table of wildcard seven-tuple flow rules with heavy-hitter and second
// thresholds; insert beats append rules, match beats scan them in order.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata item fields, s_tuser op
// m_       out  m_tvalid/m_tready  m_tdata action and index, m_tuser flags
//
// An insert passes from accept through decode to the final state. A match
// scan stops at the first deciding rule; otherwise it runs past the last
// rule and ends with no match. The result then goes to the output register.
// The scan reads one rule a cycle from the single-port rule memory.
// Reset empties the table; rule entries need no clearing pass.
// A new beat is accepted while a result waits in the output register; a
// stalled output holds the next result in the controller's final state.
// ----------------------------------------------------------------------------
module wildcard_flow_rule_matcher #(
	parameter int RULES = wfrm_pkg::RULES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// src_mac, dst_mac, src_ip, dst_ip, protocol, l4_sport, l4_dport,
	// hh_value, ss_value, action_high, action_low
	input  logic [wfrm_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// action, rule_index, zero fill
	output logic [wfrm_pkg::OUT_DATA_W-1:0] m_tdata,
	// matched, rejected
	output logic [wfrm_pkg::OUT_USER_W-1:0] m_tuser
);

	localparam int IDXW = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNTW = $clog2(RULES + 1);

	wfrm_pkg::cmd_t  cmd;
	wfrm_pkg::stat_t stat;

	wfrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wfrm_datapath #(
		.RULES (RULES),
		.IDXW  (IDXW),
		.CNTW  (CNTW)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the wildcard flow rule matcher. A short scripted run
// covers the empty table, wildcard and all-ones rules, threshold edges and a
// zero action. A random run then fills the table past full with rules that
// mix wildcards and exact fields, and sends match beats built from stored
// rules so that hits, misses and threshold ties are all common. Each result
// beat is checked against a set verdict or a shadow rule table in this file.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SCRIPT_ITEMS = 14;
	localparam int RANDOM_ITEMS = 836;
	localparam int PHASE_LEN    = RANDOM_ITEMS / 4;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic                          matched;
		logic                          rejected;
		logic [31:0]                   action;
		logic [wfrm_pkg::INDEX_W-1:0]  index;
	} verdict_t;

	typedef struct {
		logic            op;
		wfrm_pkg::rule_t data;
		logic            typed;
		verdict_t        want;
	} row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [wfrm_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [wfrm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [wfrm_pkg::OUT_USER_W-1:0] m_tuser;

	wfrm_pkg::rule_t shadow_rules [wfrm_pkg::RULES_DEF];
	int       shadow_count = 0;
	verdict_t verdict_q [$];
	row_t     script [$];
	int       errors = 0;
	int       send_idle = 0;
	int       recv_stall = 0;
	int       cycle_count = 0;

	wildcard_flow_rule_matcher #(
		.RULES(wfrm_pkg::RULES_DEF)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// Roughly a third of rule header fields become wildcards.
	function automatic logic [63:0] maybe_wild(input logic [63:0] value);
		return ($urandom_range(0, 9) < 3) ? 64'd0 : value;
	endfunction

	function automatic wfrm_pkg::rule_t pack_rule(input logic [47:0] smac,
			input logic [47:0] dmac, input logic [31:0] sip, input logic [31:0] dip,
			input logic [7:0] proto, input logic [15:0] sport, input logic [15:0] dport,
			input logic [31:0] hh, input logic [31:0] ss, input logic [31:0] act_hi,
			input logic [31:0] act_lo);
		wfrm_pkg::rule_t r;
		r.src_mac     = smac;
		r.dst_mac     = dmac;
		r.src_ip      = sip;
		r.dst_ip      = dip;
		r.protocol    = proto;
		r.l4_sport    = sport;
		r.l4_dport    = dport;
		r.hh_value    = hh;
		r.ss_value    = ss;
		r.action_high = act_hi;
		r.action_low  = act_lo;
		return r;
	endfunction

	function automatic verdict_t verdict(input logic matched, input logic [31:0] action,
			input logic [wfrm_pkg::INDEX_W-1:0] index, input logic rejected);
		verdict_t v;
		v.matched  = matched;
		v.action   = action;
		v.index    = index;
		v.rejected = rejected;
		return v;
	endfunction

	// Applies one accepted beat to the shadow table and returns the result
	// the block must give for it.
	function automatic verdict_t decide_flow(input logic op, input wfrm_pkg::rule_t pkt);
		verdict_t        v;
		wfrm_pkg::rule_t r;
		logic            hit;
		int              i;
		v = '0;
		if (op == wfrm_pkg::OP_INSERT) begin
			if (shadow_count >= wfrm_pkg::RULES_DEF) begin
				v.rejected = 1'b1;
			end else begin
				shadow_rules[shadow_count] = pkt;
				v.index = shadow_count[wfrm_pkg::INDEX_W-1:0];
				shadow_count++;
			end
			return v;
		end
		for (i = 0; i < shadow_count; i++) begin
			r = shadow_rules[i];
			hit = (r.src_mac == '0 || r.src_mac == pkt.src_mac) &&
				(r.dst_mac == '0 || r.dst_mac == pkt.dst_mac) &&
				(r.src_ip == '0 || r.src_ip == pkt.src_ip) &&
				(r.dst_ip == '0 || r.dst_ip == pkt.dst_ip) &&
				(r.protocol == '0 || r.protocol == pkt.protocol) &&
				(r.l4_sport == '0 || r.l4_sport == pkt.l4_sport) &&
				(r.l4_dport == '0 || r.l4_dport == pkt.l4_dport);
			if (hit && pkt.hh_value > r.hh_value)
				return verdict(1'b1, r.action_high, i[wfrm_pkg::INDEX_W-1:0], 1'b0);
			if (hit && pkt.ss_value > r.ss_value)
				return verdict(1'b1, r.action_low, i[wfrm_pkg::INDEX_W-1:0], 1'b0);
		end
		return v;
	endfunction

	task automatic add_row(input logic op, input wfrm_pkg::rule_t data, input logic typed,
			input verdict_t want);
		row_t row;
		row.op    = op;
		row.data  = data;
		row.typed = typed;
		row.want  = want;
		script.push_back(row);
	endtask

	// Called just after a falling edge; returns just after the falling edge
	// that follows acceptance, with tvalid still high.
	task automatic send_beat(input logic op, input wfrm_pkg::rule_t data, input logic typed,
			input verdict_t typed_want);
		verdict_t want;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		want = decide_flow(op, data);
		verdict_q.push_back(typed ? typed_want : want);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (verdict_q.size() != 0);
	endtask

	always @(posedge clk) begin : watch_results
		verdict_t got;
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.matched  = m_tuser[0];
			got.rejected = m_tuser[1];
			got.action   = m_tdata[31:0];
			got.index    = m_tdata[32 +: wfrm_pkg::INDEX_W];
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("extra result beat: matched %0b action %h index %0d rejected %0b",
						got.matched, got.action, got.index, got.rejected);
			end else begin
				want = verdict_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("mismatch, expected: matched %0b action %h index %0d rejected %0b",
							want.matched, want.action, want.index, want.rejected);
						$display("mismatch, actual:   matched %0b action %h index %0d rejected %0b",
							got.matched, got.action, got.index, got.rejected);
					end
				end
			end
		end
	end

	initial begin : stimulus
		wfrm_pkg::rule_t pkt;
		wfrm_pkg::rule_t base;
		logic            op;
		int              n;
		logic [47:0]     ones48;
		logic [31:0]     ones32;
		wfrm_pkg::rule_t tag_rule;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = wfrm_pkg::OP_MATCH;
		ones48   = '1;
		ones32   = '1;
		tag_rule = pack_rule(48'h0000_0000_0001, 48'h8000_0000_0000, 32'h0A00_0001,
			32'hC0A8_0101, 8'd6, 16'd1, 16'h8000, 32'h0001_8000, 32'd100,
			32'h0000_A5A5, 32'h0000_5A5A);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, both field extremes.
		add_row(wfrm_pkg::OP_MATCH, pack_rule(ones48, ones48, ones32, ones32, 8'hFF,
			16'hFFFF, 16'hFFFF, ones32, ones32, ones32, ones32), 1'b1,
			verdict(1'b0, '0, '0, 1'b0));
		add_row(wfrm_pkg::OP_MATCH, '0, 1'b1, verdict(1'b0, '0, '0, 1'b0));
		// Rule 0: all wildcards, thresholds that nothing can exceed.
		add_row(wfrm_pkg::OP_INSERT, pack_rule('0, '0, '0, '0, '0, '0, '0, ones32, ones32,
			ones32, ones32), 1'b1, verdict(1'b0, '0, '0, 1'b0));
		// Rule 1: all-ones header, zero thresholds, zero low action.
		add_row(wfrm_pkg::OP_INSERT, pack_rule(ones48, ones48, ones32, ones32, 8'hFF,
			16'hFFFF, 16'hFFFF, '0, '0, ones32, '0), 1'b1, verdict(1'b0, '0, 6'd1, 1'b0));
		add_row(wfrm_pkg::OP_INSERT, tag_rule, 1'b1, verdict(1'b0, '0, 6'd2, 1'b0));
		// Rule 3: all wildcards, both actions zero.
		add_row(wfrm_pkg::OP_INSERT, pack_rule('0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFE,
			'0, '0, '0), 1'b1, verdict(1'b0, '0, 6'd3, 1'b0));
		add_row(wfrm_pkg::OP_MATCH, pack_rule(ones48, ones48, ones32, ones32, 8'hFF,
			16'hFFFF, 16'hFFFF, 32'd1, '0, '0, '0), 1'b1, verdict(1'b1, ones32, 6'd1, 1'b0));
		add_row(wfrm_pkg::OP_MATCH, pack_rule(ones48, ones48, ones32, ones32, 8'hFF,
			16'hFFFF, 16'hFFFF, '0, 32'd1, '0, '0), 1'b1, verdict(1'b1, '0, 6'd1, 1'b0));
		add_row(wfrm_pkg::OP_MATCH, pack_rule(ones48, ones48, ones32, ones32, 8'hFF,
			16'hFFFF, 16'hFFFF, '0, '0, '0, '0), 1'b1, verdict(1'b0, '0, '0, 1'b0));
		// Threshold edges on rule 2: just above, equal with the second one
		// exceeded, both equal, and one header field off.
		pkt = tag_rule;
		pkt.hh_value = 32'h0001_8001;
		pkt.ss_value = '0;
		add_row(wfrm_pkg::OP_MATCH, pkt, 1'b0, '0);
		pkt.hh_value = 32'h0001_8000;
		pkt.ss_value = 32'd101;
		add_row(wfrm_pkg::OP_MATCH, pkt, 1'b0, '0);
		pkt.ss_value = 32'd100;
		add_row(wfrm_pkg::OP_MATCH, pkt, 1'b0, '0);
		pkt.protocol = 8'd17;
		pkt.hh_value = ones32;
		add_row(wfrm_pkg::OP_MATCH, pkt, 1'b0, '0);
		pkt = '0;
		pkt.hh_value = ones32;
		add_row(wfrm_pkg::OP_MATCH, pkt, 1'b0, '0);

		foreach (script[k])
			send_beat(script[k].op, script[k].data, script[k].typed, script[k].want);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				drain_results();
				case (n / PHASE_LEN)
					0: begin send_idle = 0;  recv_stall = 0;  end
					1: begin send_idle = 68; recv_stall = 0;  end
					2: begin send_idle = 0;  recv_stall = 68; end
					default: begin send_idle = 24; recv_stall = 24; end
				endcase
			end
			while ($urandom_range(0, 99) < send_idle) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end

			if ($urandom_range(0, 99) < 20) begin
				op = wfrm_pkg::OP_INSERT;
				pkt = '0;
				pkt.src_mac  = 48'(maybe_wild(rnd64()));
				pkt.dst_mac  = 48'(maybe_wild(rnd64()));
				pkt.src_ip   = 32'(maybe_wild(rnd64()));
				pkt.dst_ip   = 32'(maybe_wild(rnd64()));
				pkt.protocol = 8'(maybe_wild(rnd64()));
				pkt.l4_sport = 16'(maybe_wild(rnd64()));
				pkt.l4_dport = 16'(maybe_wild(rnd64()));
				case ($urandom_range(0, 3))
					0: pkt.hh_value = $urandom();
					1: pkt.hh_value = '0;
					2: pkt.hh_value = '1;
					default: pkt.hh_value = $urandom_range(0, 1000);
				endcase
				case ($urandom_range(0, 3))
					0: pkt.ss_value = $urandom();
					1: pkt.ss_value = '0;
					2: pkt.ss_value = '1;
					default: pkt.ss_value = $urandom_range(0, 1000);
				endcase
				pkt.action_high = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
				pkt.action_low  = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
			end else if (shadow_count > 0 && $urandom_range(0, 9) < 8) begin
				// Header taken from a stored rule, wildcards filled at random, at times one
				// bit flipped, measurements placed around that rule's thresholds.
				op = wfrm_pkg::OP_MATCH;
				base = shadow_rules[$urandom_range(0, shadow_count - 1)];
				pkt = '0;
				pkt.action_high = $urandom();
				pkt.action_low  = $urandom();
				pkt.src_mac  = (base.src_mac != '0) ? base.src_mac :
					48'(maybe_wild(rnd64()));
				pkt.dst_mac  = (base.dst_mac != '0) ? base.dst_mac :
					48'(maybe_wild(rnd64()));
				pkt.src_ip   = (base.src_ip != '0) ? base.src_ip : 32'(maybe_wild(rnd64()));
				pkt.dst_ip   = (base.dst_ip != '0) ? base.dst_ip : 32'(maybe_wild(rnd64()));
				pkt.protocol = (base.protocol != '0) ? base.protocol :
					8'(maybe_wild(rnd64()));
				pkt.l4_sport = (base.l4_sport != '0) ? base.l4_sport :
					16'(maybe_wild(rnd64()));
				pkt.l4_dport = (base.l4_dport != '0) ? base.l4_dport :
					16'(maybe_wild(rnd64()));
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 6))
						0: pkt.src_mac  ^= 48'd1 << $urandom_range(0, 47);
						1: pkt.dst_mac  ^= 48'd1 << $urandom_range(0, 47);
						2: pkt.src_ip   ^= 32'd1 << $urandom_range(0, 31);
						3: pkt.dst_ip   ^= 32'd1 << $urandom_range(0, 31);
						4: pkt.protocol ^= 8'd1 << $urandom_range(0, 7);
						5: pkt.l4_sport ^= 16'd1 << $urandom_range(0, 15);
						default: pkt.l4_dport ^= 16'd1 << $urandom_range(0, 15);
					endcase
				end
				case ($urandom_range(0, 3))
					0: pkt.hh_value = $urandom();
					1: pkt.hh_value = base.hh_value + 32'd1;
					2: pkt.hh_value = base.hh_value;
					default: pkt.hh_value = '0;
				endcase
				case ($urandom_range(0, 3))
					0: pkt.ss_value = $urandom();
					1: pkt.ss_value = base.ss_value + 32'd1;
					2: pkt.ss_value = base.ss_value;
					default: pkt.ss_value = '0;
				endcase
			end else begin
				op = wfrm_pkg::OP_MATCH;
				pkt = '0;
				pkt.action_high = $urandom();
				pkt.action_low  = $urandom();
				pkt.src_mac  = 48'(maybe_wild(rnd64()));
				pkt.dst_mac  = 48'(maybe_wild(rnd64()));
				pkt.src_ip   = 32'(maybe_wild(rnd64()));
				pkt.dst_ip   = 32'(maybe_wild(rnd64()));
				pkt.protocol = 8'(maybe_wild(rnd64()));
				pkt.l4_sport = 16'(maybe_wild(rnd64()));
				pkt.l4_dport = 16'(maybe_wild(rnd64()));
				pkt.hh_value = $urandom();
				pkt.ss_value = $urandom();
			end
			send_beat(op, pkt, 1'b0, '0);
		end

		drain_results();
		repeat (wfrm_pkg::RULES_DEF + 8) @(negedge clk);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/wfrm_pkg.sv
hw/rtl/wfrm_ctrl.sv
hw/rtl/wfrm_datapath.sv
hw/rtl/wildcard_flow_rule_matcher.sv
verif/tb_top.sv
